/* hdl/tbpe_pkg.sv */
// Shared types and constants of the tape block pulse encoder.
// No dependencies; every other file of the block refers to it by scoped name.
package tbpe_pkg;

  // block lengths that select the lead-in form
  localparam logic [15:0] LEN_HEADER = 16'd19;
  localparam logic [15:0] LEN_PAUSE  = 16'd20;

  // register defaults
  localparam logic [15:0] RST_PILOT_HALF    = 16'd2168;
  localparam logic [15:0] RST_SYNC_FIRST    = 16'd667;
  localparam logic [15:0] RST_SYNC_SECOND   = 16'd735;
  localparam logic [15:0] RST_ONE_HALF      = 16'd1710;
  localparam logic [15:0] RST_ZERO_HALF     = 16'd855;
  localparam logic [15:0] RST_GAP_LENGTH    = 16'd1000;
  localparam logic [15:0] RST_HEADER_PILOTS = 16'd16126;  // 8063 * 2
  localparam logic [15:0] RST_DATA_PILOTS   = 16'd6466;   // 3233 * 2

  // register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_HALF    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_PILOTS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_PILOTS   = 4'd7;

  // run kinds on the result port
  localparam logic [1:0] RUN_PULSES = 2'd0;
  localparam logic [1:0] RUN_PAUSE  = 2'd1;
  localparam logic [1:0] RUN_END    = 2'd2;

  // input kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  // commands passed from front to back
  localparam logic [2:0] OP_END       = 3'd0;  // end marker
  localparam logic [2:0] OP_HEADER    = 3'd1;  // gap, header pilot, sync
  localparam logic [2:0] OP_PAUSE     = 3'd2;  // pause marker, data pilot, sync
  localparam logic [2:0] OP_BLOCK     = 3'd3;  // gap, data pilot, sync
  localparam logic [2:0] OP_BYTE      = 3'd4;  // eight bits
  localparam logic [2:0] OP_BYTE_LAST = 3'd5;  // eight bits then gap

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pilot_half_period;
    logic [15:0] sync_first_half;
    logic [15:0] sync_second_half;
    logic [15:0] one_half_period;
    logic [15:0] zero_half_period;
    logic [15:0] gap_length;
    logic [15:0] header_pilot_count;
    logic [15:0] data_pilot_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  run_kind;
    logic        start_level;
    logic [15:0] half_period;
    logic [15:0] half_count;
    logic        last_of_item;
  } result_t;

endpackage

/* hdl/tbpe_front.sv */
// Front end: parses the tape image byte stream into block commands.
// Uses tbpe_pkg.
module tbpe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  output logic             cmd_push,
  output tbpe_pkg::cmd_t   cmd
);

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  length_low_r, length_low_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] len;
  logic [15:0] left_dec;

  assign len      = {data_byte, length_low_r};
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    length_low_nxt = length_low_r;
    bytes_left_nxt = bytes_left_r;
    cmd_push       = 1'b0;
    cmd.op         = tbpe_pkg::OP_END;
    cmd.data       = data_byte;
    if (accept && phase_r != PH_STOP) begin
      if (kind == tbpe_pkg::IN_END) begin
        cmd_push  = 1'b1;
        cmd.op    = tbpe_pkg::OP_END;
        phase_nxt = PH_STOP;
      end else begin
        unique case (phase_r)
          PH_LOW: begin
            length_low_nxt = data_byte;
            phase_nxt      = PH_HIGH;
          end
          PH_HIGH: begin
            bytes_left_nxt = len;
            cmd_push       = 1'b1;
            phase_nxt      = PH_DATA;
            priority if (len == 16'd0) begin
              cmd.op    = tbpe_pkg::OP_END;
              phase_nxt = PH_STOP;
            end else if (len == tbpe_pkg::LEN_HEADER) begin
              cmd.op = tbpe_pkg::OP_HEADER;
            end else if (len == tbpe_pkg::LEN_PAUSE) begin
              cmd.op = tbpe_pkg::OP_PAUSE;
            end else begin
              cmd.op = tbpe_pkg::OP_BLOCK;
            end
          end
          PH_DATA: begin
            bytes_left_nxt = left_dec;
            cmd_push       = 1'b1;
            if (left_dec == 16'd0) begin
              cmd.op    = tbpe_pkg::OP_BYTE_LAST;
              phase_nxt = PH_LOW;
            end else begin
              cmd.op = tbpe_pkg::OP_BYTE;
            end
          end
          default: begin
            phase_nxt = PH_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LOW;
      length_low_r <= 8'd0;
      bytes_left_r <= 16'd0;
    end else begin
      phase_r      <= phase_nxt;
      length_low_r <= length_low_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

/* hdl/tbpe_cmd_fifo.sv */
// Short command queue between front end and run sequencer.
// Uses tbpe_pkg.
module tbpe_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbpe_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tbpe_pkg::cmd_t  head
);

  tbpe_pkg::cmd_t slot_r [tbpe_pkg::CMD_DEPTH];
  logic [tbpe_pkg::CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tbpe_pkg::CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tbpe_pkg::CMD_CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == tbpe_pkg::CMD_CNT_W'(tbpe_pkg::CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/tbpe_back.sv */
// Run sequencer: expands each command into tape runs, one per cycle while the
// result port is not stalled, into a result register. Uses tbpe_pkg.
module tbpe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tbpe_pkg::cfg_t    cfg,
  input  logic              cmd_valid,
  input  tbpe_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              res_pop,
  output logic              res_valid,
  output tbpe_pkg::result_t res
);

  logic [3:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  tbpe_pkg::result_t res_r;
  tbpe_pkg::result_t run;
  logic [3:0]        last_step;
  logic              emit;
  logic              take;
  logic [15:0]       pilots;
  logic              bit_val;

  assign take  = res_pop && out_valid_r;
  assign emit  = cmd_valid && (!out_valid_r || take);

  always_comb begin
    unique case (cmd.op)
      tbpe_pkg::OP_END:       last_step = 4'd0;
      tbpe_pkg::OP_BYTE:      last_step = 4'd7;
      tbpe_pkg::OP_BYTE_LAST: last_step = 4'd8;
      default:                last_step = 4'd3;
    endcase
  end

  assign pilots  = (cmd.op == tbpe_pkg::OP_HEADER) ? cfg.header_pilot_count
                                                   : cfg.data_pilot_count;
  assign bit_val = cmd.data[3'd7 - step_r[2:0]];

  always_comb begin
    run.run_kind     = tbpe_pkg::RUN_PULSES;
    run.start_level  = 1'b1;
    run.half_period  = cfg.gap_length;
    run.half_count   = 16'd1;
    run.last_of_item = (step_r == last_step);
    unique case (cmd.op)
      tbpe_pkg::OP_BYTE, tbpe_pkg::OP_BYTE_LAST: begin
        if (!step_r[3]) begin
          run.half_period = bit_val ? cfg.one_half_period : cfg.zero_half_period;
          run.half_count  = 16'd2;
        end
      end
      tbpe_pkg::OP_HEADER, tbpe_pkg::OP_PAUSE, tbpe_pkg::OP_BLOCK: begin
        unique case (step_r[1:0])
          2'd0: begin
            if (cmd.op == tbpe_pkg::OP_PAUSE) begin
              run.run_kind    = tbpe_pkg::RUN_PAUSE;
              run.start_level = 1'b0;
              run.half_period = 16'd0;
              run.half_count  = 16'd0;
            end
          end
          2'd1: begin
            // pilot ends on a low half
            run.start_level = ~pilots[0];
            run.half_period = cfg.pilot_half_period;
            run.half_count  = pilots;
          end
          2'd2: begin
            run.half_period = cfg.sync_first_half;
          end
          default: begin
            run.start_level = 1'b0;
            run.half_period = cfg.sync_second_half;
          end
        endcase
      end
      default: begin
        run.run_kind    = tbpe_pkg::RUN_END;
        run.start_level = 1'b0;
        run.half_period = 16'd0;
        run.half_count  = 16'd0;
      end
    endcase
  end

  assign cmd_pop = emit && run.last_of_item;

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      step_nxt = run.last_of_item ? 4'd0 : step_r + 4'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (take ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

/* hdl/tap_block_pulse_encoder_top.sv */
// Tape block pulse encoder, top level: register file, front end, command
// queue and run sequencer. Uses tbpe_pkg, tbpe_front, tbpe_cmd_fifo, tbpe_back.
//
// Takes a tape image one byte per beat and gives runs of tape half-pulses,
// one run per result beat. The front end parses the length prefix of each
// block and queues one command per byte that produces output (a length low
// byte, and anything after the end marker, produce nothing); the run
// sequencer turns each command into its runs at one run per clock unless the
// result port stalls. A length high byte yields four runs (gap or pause
// marker, pilot, two sync halves), a data byte eight bit runs, the last byte
// of a block nine (a trailing gap), and a zero length or an end beat a single
// end marker, after which input is swallowed until reset. Sustained throughput
// is one result per cycle when unstalled, so data bytes are paced at eight or
// nine runs each; the first run of a byte passes the command queue and then
// the result register to the result ports. A four-entry command queue lets
// in_push beats keep landing while the result port is stalled. Registers (16
// bits, index 0..7) are written through cfg_*, always ready; indexes 8..15
// are dropped. Write them only while the block is idle.
module tap_block_pulse_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // input queue side
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  // result queue side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_run_kind,
  output logic        out_start_level,
  output logic [15:0] out_half_period,
  output logic [15:0] out_half_count,
  output logic        out_last_of_item,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tbpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  tbpe_pkg::cfg_t    cfg_r, cfg_nxt;
  tbpe_pkg::cmd_t    front_cmd;
  tbpe_pkg::cmd_t    head_cmd;
  tbpe_pkg::result_t res;
  logic              front_push;
  logic              q_empty;
  logic              q_pop;
  logic              res_valid;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  // register file; out-of-range indexes fall through the default arm
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tbpe_pkg::REG_PILOT_HALF:    cfg_nxt.pilot_half_period  = cfg_wdata;
        tbpe_pkg::REG_SYNC_FIRST:    cfg_nxt.sync_first_half    = cfg_wdata;
        tbpe_pkg::REG_SYNC_SECOND:   cfg_nxt.sync_second_half   = cfg_wdata;
        tbpe_pkg::REG_ONE_HALF:      cfg_nxt.one_half_period    = cfg_wdata;
        tbpe_pkg::REG_ZERO_HALF:     cfg_nxt.zero_half_period   = cfg_wdata;
        tbpe_pkg::REG_GAP_LENGTH:    cfg_nxt.gap_length         = cfg_wdata;
        tbpe_pkg::REG_HEADER_PILOTS: cfg_nxt.header_pilot_count = cfg_wdata;
        tbpe_pkg::REG_DATA_PILOTS:   cfg_nxt.data_pilot_count   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pilot_half_period  <= tbpe_pkg::RST_PILOT_HALF;
      cfg_r.sync_first_half    <= tbpe_pkg::RST_SYNC_FIRST;
      cfg_r.sync_second_half   <= tbpe_pkg::RST_SYNC_SECOND;
      cfg_r.one_half_period    <= tbpe_pkg::RST_ONE_HALF;
      cfg_r.zero_half_period   <= tbpe_pkg::RST_ZERO_HALF;
      cfg_r.gap_length         <= tbpe_pkg::RST_GAP_LENGTH;
      cfg_r.header_pilot_count <= tbpe_pkg::RST_HEADER_PILOTS;
      cfg_r.data_pilot_count   <= tbpe_pkg::RST_DATA_PILOTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: length parsing and block state
  tbpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .kind      (in_kind),
    .data_byte (in_data_byte),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  // in_full comes straight from the queue: a beat is only taken when a
  // command slot is free, whether or not that beat produces a command
  tbpe_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  // run sequencer with its result register
  tbpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty        = !res_valid;
  assign out_run_kind     = res.run_kind;
  assign out_start_level  = res.start_level;
  assign out_half_period  = res.half_period;
  assign out_half_count   = res.half_count;
  assign out_last_of_item = res.last_of_item;

endmodule
